// ===== design/background_pixel_removal_defines.svh =====
`ifndef BACKGROUND_PIXEL_REMOVAL_DEFINES_SVH
`define BACKGROUND_PIXEL_REMOVAL_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define BPR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("property violated");

// Next-cycle implication, disabled while reset is asserted
`define BPR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("property violated");

`endif

// ===== design/bpr_pkg.sv =====
package bpr_pkg;

	localparam int PIX_W      = 8;
	localparam int SUM_W      = 10;
	localparam int PROD_W     = 2 * PIX_W;
	localparam int WIDE_W     = PROD_W + PIX_W;
	localparam int LUMA_W     = 9;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 9;

	// floor(s/3) for s <= 765 as (s * 683) >> 11
	localparam int LUMA_RECIP = 683;
	localparam int LUMA_SHIFT = 11;

	localparam logic [CFG_IDX_W-1:0] REG_COLOR_THRESHOLD = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_LUMA        = 1'b1;

	localparam logic [PIX_W-1:0]  THR_RESET  = 8'd30;
	localparam logic [LUMA_W-1:0] LUMA_RESET = 9'd0;

	typedef enum logic [1:0] {
		DEC_KEPT   = 2'd0,
		DEC_MATCH  = 2'd1,
		DEC_SHADOW = 2'd2
	} dec_t;

	typedef struct packed {
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
	} rgb_t;

	typedef struct packed {
		logic             valid;
		rgb_t             pix;
		logic [PIX_W-1:0] extra;
		rgb_t             bg;
		logic [PIX_W-1:0] y;
		logic [PIX_W-1:0] by;
		logic             match;
		logic             big;
	} front_t;

	typedef struct packed {
		logic              valid;
		rgb_t              pix;
		logic [PIX_W-1:0]  extra;
		logic              resolved;
		dec_t              dec;
		logic [WIDE_W-1:0] lhs_r;
		logic [WIDE_W-1:0] lhs_g;
		logic [WIDE_W-1:0] lhs_b;
		logic [WIDE_W-1:0] rhs;
	} shadow_t;

endpackage

// ===== design/bpr_front.sv =====
module bpr_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  bpr_pkg::rgb_t              pix,
	input  logic [bpr_pkg::PIX_W-1:0]  extra,
	input  bpr_pkg::rgb_t              bg,
	input  logic [bpr_pkg::PIX_W-1:0]  thr,
	output bpr_pkg::front_t            st
);
	import bpr_pkg::*;

	logic             v_s1;
	rgb_t             pix_s1;
	rgb_t             bg_s1;
	logic [PIX_W-1:0] extra_s1;
	logic [PIX_W-1:0] dr_s1, dg_s1, db_s1;
	logic [SUM_W-1:0] sum_s1, bsum_s1;

	logic             v_s2;
	rgb_t             pix_s2;
	rgb_t             bg_s2;
	logic [PIX_W-1:0] extra_s2;
	logic [PIX_W-1:0] y_s2, by_s2;
	logic             match_s2, big_s2;

	logic [2*SUM_W-1:0] yp, byp;
	logic [PIX_W:0]     thr2;
	logic               match, big;

	function automatic logic [PIX_W-1:0] absdiff(input logic [PIX_W-1:0] a,
		input logic [PIX_W-1:0] b);
		absdiff = (a > b) ? a - b : b - a;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		pix_s1   <= pix;
		bg_s1    <= bg;
		extra_s1 <= extra;
		dr_s1    <= absdiff(pix.red, bg.red);
		dg_s1    <= absdiff(pix.green, bg.green);
		db_s1    <= absdiff(pix.blue, bg.blue);
		sum_s1   <= SUM_W'(pix.red) + SUM_W'(pix.green) + SUM_W'(pix.blue);
		bsum_s1  <= SUM_W'(bg.red) + SUM_W'(bg.green) + SUM_W'(bg.blue);
	end

	// divide by three through the reciprocal
	assign yp   = (2*SUM_W)'(sum_s1) * (2*SUM_W)'(LUMA_RECIP);
	assign byp  = (2*SUM_W)'(bsum_s1) * (2*SUM_W)'(LUMA_RECIP);
	assign thr2 = {thr, 1'b0};

	assign match = (dr_s1 < thr) && (dg_s1 < thr) && (db_s1 < thr);
	assign big   = ({1'b0, dr_s1} > thr2) || ({1'b0, dg_s1} > thr2) ||
		({1'b0, db_s1} > thr2);

	always_ff @(posedge clk) begin
		pix_s2   <= pix_s1;
		bg_s2    <= bg_s1;
		extra_s2 <= extra_s1;
		y_s2     <= yp[LUMA_SHIFT +: PIX_W];
		by_s2    <= byp[LUMA_SHIFT +: PIX_W];
		match_s2 <= match;
		big_s2   <= big;
	end

	always_comb begin
		st.valid = v_s2;
		st.pix   = pix_s2;
		st.extra = extra_s2;
		st.bg    = bg_s2;
		st.y     = y_s2;
		st.by    = by_s2;
		st.match = match_s2;
		st.big   = big_s2;
	end

endmodule

// ===== design/bpr_shadow.sv =====
module bpr_shadow (
	input  logic                       clk,
	input  logic                       arst_n,
	input  bpr_pkg::front_t            st_in,
	input  logic [bpr_pkg::PIX_W-1:0]  thr,
	input  logic [bpr_pkg::LUMA_W-1:0] min_luma,
	output bpr_pkg::shadow_t           st
);
	import bpr_pkg::*;

	logic              v_s3;
	rgb_t              pix_s3;
	logic [PIX_W-1:0]  extra_s3;
	logic [PROD_W-1:0] cr_s3, cg_s3, cb_s3;
	logic [PROD_W-1:0] br_s3, bgr_s3, bb_s3;
	logic [PROD_W-1:0] yby_s3;
	logic              res_s3;
	dec_t              dec_s3;

	logic              v_s4;
	rgb_t              pix_s4;
	logic [PIX_W-1:0]  extra_s4;
	logic              res_s4;
	dec_t              dec_s4;
	logic [WIDE_W-1:0] lhs_r_s4, lhs_g_s4, lhs_b_s4, rhs_s4;

	logic              dark, not_darker, zero;
	logic              res;
	dec_t              dec;

	function automatic logic [PROD_W-1:0] absdiff(input logic [PROD_W-1:0] a,
		input logic [PROD_W-1:0] b);
		absdiff = (a > b) ? a - b : b - a;
	endfunction

	assign dark = ({1'b0, st_in.by} < min_luma) || ({1'b0, st_in.y} < min_luma);
	// 2Y + T > 2bY keeps the pixel
	assign not_darker = (SUM_W'({st_in.y, 1'b0}) + SUM_W'(thr)) > SUM_W'({st_in.by, 1'b0});
	assign zero = (st_in.y == '0) || (st_in.by == '0);

	always_comb begin
		if (st_in.match) begin
			res = 1'b1;
			dec = DEC_MATCH;
		end else if (st_in.big || dark || not_darker || zero) begin
			res = 1'b1;
			dec = DEC_KEPT;
		end else begin
			res = 1'b0;
			dec = DEC_KEPT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s3 <= st_in.valid;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		pix_s3   <= st_in.pix;
		extra_s3 <= st_in.extra;
		cr_s3    <= PROD_W'(st_in.pix.red) * PROD_W'(st_in.by);
		cg_s3    <= PROD_W'(st_in.pix.green) * PROD_W'(st_in.by);
		cb_s3    <= PROD_W'(st_in.pix.blue) * PROD_W'(st_in.by);
		br_s3    <= PROD_W'(st_in.bg.red) * PROD_W'(st_in.y);
		bgr_s3   <= PROD_W'(st_in.bg.green) * PROD_W'(st_in.y);
		bb_s3    <= PROD_W'(st_in.bg.blue) * PROD_W'(st_in.y);
		yby_s3   <= PROD_W'(st_in.y) * PROD_W'(st_in.by);
		res_s3   <= res;
		dec_s3   <= dec;
	end

	// scale the cross difference by 256, the bound by T
	always_ff @(posedge clk) begin
		pix_s4   <= pix_s3;
		extra_s4 <= extra_s3;
		res_s4   <= res_s3;
		dec_s4   <= dec_s3;
		lhs_r_s4 <= {absdiff(cr_s3, br_s3), 8'd0};
		lhs_g_s4 <= {absdiff(cg_s3, bgr_s3), 8'd0};
		lhs_b_s4 <= {absdiff(cb_s3, bb_s3), 8'd0};
		rhs_s4   <= WIDE_W'(thr) * WIDE_W'(yby_s3);
	end

	always_comb begin
		st.valid    = v_s4;
		st.pix      = pix_s4;
		st.extra    = extra_s4;
		st.resolved = res_s4;
		st.dec      = dec_s4;
		st.lhs_r    = lhs_r_s4;
		st.lhs_g    = lhs_g_s4;
		st.lhs_b    = lhs_b_s4;
		st.rhs      = rhs_s4;
	end

endmodule

// ===== design/background_pixel_removal.sv =====
// Channel   Ports                                      Handshake
// input     in_red in_green in_blue in_extra           start, taken when busy is low
//           bg_red bg_green bg_blue
// config    cfg_index cfg_data                         cfg_write, taken at once
// result    out_red out_green out_blue out_extra       done, one cycle, no stall
//           decision
//
// One pixel per clock; busy stays low, so every start beat is taken.
// Five register stages, s1 to s5; done is the s5 valid bit.
// The stages carry the luma divide, the cross products and T * Y * bY.
// Reset clears the valid bits and loads T = 30, min_luma = 0.
// The receiver cannot stall, so the pipeline never holds.
`include "background_pixel_removal_defines.svh"

module background_pixel_removal (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [bpr_pkg::PIX_W-1:0]      in_red,
	input  logic [bpr_pkg::PIX_W-1:0]      in_green,
	input  logic [bpr_pkg::PIX_W-1:0]      in_blue,
	input  logic [bpr_pkg::PIX_W-1:0]      in_extra,
	input  logic [bpr_pkg::PIX_W-1:0]      bg_red,
	input  logic [bpr_pkg::PIX_W-1:0]      bg_green,
	input  logic [bpr_pkg::PIX_W-1:0]      bg_blue,
	input  logic                           cfg_write,
	input  logic [bpr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bpr_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                           done,
	output logic [bpr_pkg::PIX_W-1:0]      out_red,
	output logic [bpr_pkg::PIX_W-1:0]      out_green,
	output logic [bpr_pkg::PIX_W-1:0]      out_blue,
	output logic [bpr_pkg::PIX_W-1:0]      out_extra,
	output logic [1:0]                     decision
);
	import bpr_pkg::*;

	logic [PIX_W-1:0]  thr_q;
	logic [LUMA_W-1:0] min_luma_q;

	rgb_t    pix, bg;
	front_t  st_s2;
	shadow_t st_s4;

	logic             v_s5;
	logic [PIX_W-1:0] red_s5, green_s5, blue_s5, extra_s5;
	dec_t             dec_s5;
	dec_t             dec;
	logic             out_zero;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q      <= THR_RESET;
			min_luma_q <= LUMA_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_COLOR_THRESHOLD: thr_q      <= cfg_data[PIX_W-1:0];
				REG_MIN_LUMA:        min_luma_q <= cfg_data[LUMA_W-1:0];
				default: ;
			endcase
		end
	end

	assign pix = '{red: in_red, green: in_green, blue: in_blue};
	assign bg  = '{red: bg_red, green: bg_green, blue: bg_blue};

	bpr_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.pix    (pix),
		.extra  (in_extra),
		.bg     (bg),
		.thr    (thr_q),
		.st     (st_s2)
	);

	bpr_shadow u_shadow (
		.clk      (clk),
		.arst_n   (arst_n),
		.st_in    (st_s2),
		.thr      (thr_q),
		.min_luma (min_luma_q),
		.st       (st_s4)
	);

	// shadow when every channel's chroma difference is under the bound
	always_comb begin
		if (st_s4.resolved) begin
			dec = st_s4.dec;
		end else if ((st_s4.lhs_r < st_s4.rhs) && (st_s4.lhs_g < st_s4.rhs) &&
			(st_s4.lhs_b < st_s4.rhs)) begin
			dec = DEC_SHADOW;
		end else begin
			dec = DEC_KEPT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else begin
			v_s5 <= st_s4.valid;
		end
	end

	// drop the pixel bytes unless kept
	always_ff @(posedge clk) begin
		dec_s5 <= dec;
		if (dec == DEC_KEPT) begin
			red_s5   <= st_s4.pix.red;
			green_s5 <= st_s4.pix.green;
			blue_s5  <= st_s4.pix.blue;
			extra_s5 <= st_s4.extra;
		end else begin
			red_s5   <= '0;
			green_s5 <= '0;
			blue_s5  <= '0;
			extra_s5 <= '0;
		end
	end

	assign done      = v_s5;
	assign out_red   = red_s5;
	assign out_green = green_s5;
	assign out_blue  = blue_s5;
	assign out_extra = extra_s5;
	assign decision  = dec_s5;

	assign out_zero = (out_red == '0) && (out_green == '0) && (out_blue == '0) &&
		(out_extra == '0);

	`BPR_ASSERT_NEXT(a_s4_beat_delivered, clk, arst_n, st_s4.valid, done)
	`BPR_ASSERT_NEXT(a_no_spurious_beat, clk, arst_n, !st_s4.valid, !done)
	`BPR_ASSERT_IMPLY(a_removed_is_zero, clk, arst_n, done && (decision != DEC_KEPT), out_zero)

endmodule
